@@ design/dplc_pkg.sv @@
// Shared types and constants for the dual-policy LRU cache model.
package dplc_pkg;

    localparam int MAX_SETS_DEF   = 256;
    localparam int MAX_WAYS_DEF   = 8;
    localparam int ADDR_WIDTH_DEF = 32;
    localparam int CNT_W          = 32;
    localparam int OFF_W          = 5;
    localparam int IDX_W          = 4;
    localparam int WAYS_W         = 4;
    localparam int CFG_W          = 5;
    localparam int CFG_IDX_W      = 2;
    localparam int SET_SEL_W      = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_BITS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_INDEX_BITS  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_WAYS_IN_USE = 2'd2;

    localparam logic REQ_READ  = 1'b0;
    localparam logic REQ_WRITE = 1'b1;

    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_SCAN,
        S_WRITE
    } t_dplc_state;

endpackage

@@ design/dplc_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module dplc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ design/dual_policy_lru_cache_model.sv @@
// Top level of the dual-policy (write-through / write-back) LRU cache model.
// Usage:
//   Input channel i_in_valid / o_in_stall carries one access item: request
//   type and byte address. Output channel o_out_valid / i_out_stall returns one
//   item per access: hit and memory-reference flags for both policies, a
//   write-back dirty-eviction flag and five saturating running totals.
//   Configuration (offset bits, index bits, ways in use) is to be written by
//   the user through i_cfg_we / i_cfg_index / i_cfg_wdata only while the
//   block is idle; the block itself does not enforce this. Each tag store
//   keeps one set per row of a set memory. A shared per-way compare step
//   scans the set one way per cycle. Each item goes through a set read, a
//   scan of the ways in use and a row write-back that also registers the
//   result. A new item is accepted only once the block is idle again, even
//   while the previous result still waits in the output register.
//   If the receiver stalls and a result is still held, the write-back step
//   waits until the output register frees up.
//   Reset clears counters, configuration to 4/6/4, and per-set valid flags,
//   so every set reads as empty with ages equal to way number; there is no
//   clearing pass.
module dual_policy_lru_cache_model #(
    parameter int MAX_SETS   = dplc_pkg::MAX_SETS_DEF,
    parameter int MAX_WAYS   = dplc_pkg::MAX_WAYS_DEF,
    parameter int ADDR_WIDTH = dplc_pkg::ADDR_WIDTH_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [dplc_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [dplc_pkg::CFG_W-1:0]     i_cfg_wdata,
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  logic                           i_req_type,
    input  logic [ADDR_WIDTH-1:0]          i_address,
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output logic                           o_wt_hit,
    output logic                           o_wt_mem_access,
    output logic                           o_wb_hit,
    output logic                           o_wb_mem_access,
    output logic                           o_wb_dirty_evict,
    output logic [dplc_pkg::CNT_W-1:0]     o_total_refs,
    output logic [dplc_pkg::CNT_W-1:0]     o_wt_hit_total,
    output logic [dplc_pkg::CNT_W-1:0]     o_wt_mem_total,
    output logic [dplc_pkg::CNT_W-1:0]     o_wb_hit_total,
    output logic [dplc_pkg::CNT_W-1:0]     o_wb_mem_total
);

    localparam int SW   = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1;
    localparam int AW   = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
    localparam int WNW  = $clog2(MAX_WAYS + 1);
    localparam int TW   = ADDR_WIDTH;
    localparam int EW   = TW + AW + 2;
    localparam int RW   = EW * MAX_WAYS;
    localparam int SHW  = dplc_pkg::OFF_W + 1;
    localparam int CW   = dplc_pkg::CNT_W;
    localparam logic [CW-1:0] CNT_MAX = {CW{1'b1}};
    localparam logic [SW-1:0] SET_MASK = SW'(MAX_SETS - 1);

    function automatic logic [RW-1:0] reset_row();
        logic [RW-1:0] row;
        row = '0;
        for (int w = 0; w < MAX_WAYS; w++) begin
            row[w*EW + 2 +: AW] = AW'(w);
        end
        return row;
    endfunction

    localparam logic [RW-1:0] RESET_ROW = reset_row();

    function automatic logic [RW-1:0] touch_row(
        input logic [RW-1:0]  row,
        input logic [AW-1:0]  way,
        input logic [WNW-1:0] ways
    );
        logic [RW-1:0] res;
        logic [AW-1:0] old_age;
        logic [AW-1:0] age;
        res     = row;
        old_age = row[way*EW + 2 +: AW];
        for (int w = 0; w < MAX_WAYS; w++) begin
            age = row[w*EW + 2 +: AW];
            if (WNW'(w) < ways) begin
                if (AW'(w) == way) begin
                    res[w*EW + 2 +: AW] = '0;
                end else if (age < old_age) begin
                    res[w*EW + 2 +: AW] = age + AW'(1);
                end
            end
        end
        return res;
    endfunction

    function automatic logic [CW-1:0] sat_inc(input logic [CW-1:0] c, input logic en);
        return (en && c != CNT_MAX) ? c + CW'(1) : c;
    endfunction

    dplc_pkg::t_dplc_state r_state, n_state;

    logic [dplc_pkg::OFF_W-1:0]  r_off;
    logic [dplc_pkg::IDX_W-1:0]  r_idx;
    logic [dplc_pkg::WAYS_W-1:0] r_ways_cfg;

    logic          r_is_write;
    logic [TW-1:0] r_tag;
    logic [SW-1:0] r_set;
    logic [AW-1:0] r_way;

    logic          r_wt_hit, r_wt_inv, r_wb_hit, r_wb_inv;
    logic [AW-1:0] r_wt_hway, r_wt_iway, r_wt_bway, r_wt_bage;
    logic [AW-1:0] r_wb_hway, r_wb_iway, r_wb_bway, r_wb_bage;

    logic [MAX_SETS-1:0] r_row_vld;

    logic          r_out_valid;
    logic          r_o_wt_hit, r_o_wt_mem, r_o_wb_hit, r_o_wb_mem, r_o_wb_evict;
    logic [CW-1:0] r_tot, r_wt_hit_tot, r_wt_mem_tot, r_wb_hit_tot, r_wb_mem_tot;

    logic in_acc, out_acc, scan_en, write_en, scan_last;
    logic [WNW-1:0] ways_eff;
    logic [4:0] ways_ext;

    logic [ADDR_WIDTH-1:0] blk;
    logic [SHW-1:0] tshift;
    logic [dplc_pkg::SET_SEL_W-1:0] idx_mask;
    logic [SW-1:0] set_in;
    logic [TW-1:0] tag_in;

    logic [RW-1:0] wt_rdata, wb_rdata, wt_row, wb_row, wt_new, wb_new;
    logic [EW-1:0] wt_ent, wb_ent;
    logic          wt_vld, wb_vld;
    logic [AW-1:0] wt_age, wb_age;
    logic [TW-1:0] wt_tagr, wb_tagr;

    logic [AW-1:0] wt_vict, wb_vict, wb_way;
    logic          wb_evict;
    logic          wt_mem, wb_mem;

    // Geometry
    assign ways_ext = {1'b0, r_ways_cfg};
    assign ways_eff = (r_ways_cfg == '0) ? WNW'(1) :
                      (ways_ext > 5'(MAX_WAYS)) ? WNW'(MAX_WAYS) : WNW'(ways_ext);

    assign blk      = i_address >> r_off;
    assign tshift   = SHW'(r_off) + SHW'(r_idx);
    assign tag_in   = i_address >> tshift;
    assign idx_mask = (dplc_pkg::SET_SEL_W'(1) << r_idx) - dplc_pkg::SET_SEL_W'(1);
    assign set_in   = SW'(blk[dplc_pkg::SET_SEL_W-1:0] & idx_mask) & SET_MASK;

    // Set memories
    dplc_ram #(.WIDTH(RW), .DEPTH(MAX_SETS)) u_wt_ram (
        .i_clk  (i_clk),
        .i_we   (write_en),
        .i_waddr(r_set),
        .i_wdata(wt_new),
        .i_raddr(r_set),
        .o_rdata(wt_rdata)
    );

    dplc_ram #(.WIDTH(RW), .DEPTH(MAX_SETS)) u_wb_ram (
        .i_clk  (i_clk),
        .i_we   (write_en),
        .i_waddr(r_set),
        .i_wdata(wb_new),
        .i_raddr(r_set),
        .o_rdata(wb_rdata)
    );

    assign wt_row = r_row_vld[r_set] ? wt_rdata : RESET_ROW;
    assign wb_row = r_row_vld[r_set] ? wb_rdata : RESET_ROW;

    // Shared per-way compare step
    assign wt_ent  = wt_row[r_way*EW +: EW];
    assign wb_ent  = wb_row[r_way*EW +: EW];
    assign wt_vld  = wt_ent[0];
    assign wb_vld  = wb_ent[0];
    assign wt_age  = wt_ent[2 +: AW];
    assign wb_age  = wb_ent[2 +: AW];
    assign wt_tagr = wt_ent[2 + AW +: TW];
    assign wb_tagr = wb_ent[2 + AW +: TW];

    assign scan_last = (WNW'(r_way) + WNW'(1)) == ways_eff;

    // Update
    assign wt_vict  = r_wt_inv ? r_wt_iway : r_wt_bway;
    assign wb_vict  = r_wb_inv ? r_wb_iway : r_wb_bway;
    assign wb_way   = r_wb_hit ? r_wb_hway : wb_vict;
    assign wb_evict = !r_wb_hit && wb_row[wb_vict*EW] && wb_row[wb_vict*EW + 1];
    assign wt_mem   = r_is_write || !r_wt_hit;
    assign wb_mem   = !r_wb_hit;

    always_comb begin
        logic [RW-1:0] row;
        row = wt_row;
        if (r_wt_hit) begin
            row = touch_row(wt_row, r_wt_hway, ways_eff);
        end else if (r_is_write == dplc_pkg::REQ_READ) begin
            row[wt_vict*EW]               = 1'b1;
            row[wt_vict*EW + 2 + AW +: TW] = r_tag;
            row = touch_row(row, wt_vict, ways_eff);
        end
        wt_new = row;
    end

    always_comb begin
        logic [RW-1:0] row;
        row = wb_row;
        if (r_wb_hit) begin
            if (r_is_write) begin
                row[wb_way*EW + 1] = 1'b1;
            end
        end else begin
            row[wb_way*EW]                = 1'b1;
            row[wb_way*EW + 1]            = r_is_write;
            row[wb_way*EW + 2 + AW +: TW] = r_tag;
        end
        wb_new = touch_row(row, wb_way, ways_eff);
    end

    // Sequencer
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            dplc_pkg::S_IDLE:  if (i_in_valid) n_state = dplc_pkg::S_READ;
            dplc_pkg::S_READ:  n_state = dplc_pkg::S_SCAN;
            dplc_pkg::S_SCAN:  if (scan_last) n_state = dplc_pkg::S_WRITE;
            dplc_pkg::S_WRITE: if (!(r_out_valid && i_out_stall)) n_state = dplc_pkg::S_IDLE;
            default:           n_state = dplc_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        o_in_stall = 1'b1;
        scan_en    = 1'b0;
        write_en   = 1'b0;
        unique case (r_state)
            dplc_pkg::S_IDLE:  o_in_stall = 1'b0;
            dplc_pkg::S_READ:  o_in_stall = 1'b1;
            dplc_pkg::S_SCAN:  scan_en = 1'b1;
            dplc_pkg::S_WRITE: write_en = !(r_out_valid && i_out_stall);
            default:           o_in_stall = 1'b1;
        endcase
    end

    assign in_acc  = i_in_valid && !o_in_stall;
    assign out_acc = r_out_valid && !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= dplc_pkg::S_IDLE;
            r_off        <= dplc_pkg::OFF_W'(4);
            r_idx        <= dplc_pkg::IDX_W'(6);
            r_ways_cfg   <= dplc_pkg::WAYS_W'(4);
            r_row_vld    <= '0;
            r_out_valid  <= 1'b0;
            r_tot        <= '0;
            r_wt_hit_tot <= '0;
            r_wt_mem_tot <= '0;
            r_wb_hit_tot <= '0;
            r_wb_mem_tot <= '0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                case (i_cfg_index)
                    dplc_pkg::CFG_OFFSET_BITS: r_off      <= i_cfg_wdata;
                    dplc_pkg::CFG_INDEX_BITS:  r_idx      <= i_cfg_wdata[dplc_pkg::IDX_W-1:0];
                    dplc_pkg::CFG_WAYS_IN_USE: r_ways_cfg <= i_cfg_wdata[dplc_pkg::WAYS_W-1:0];
                    default: ;
                endcase
            end
            if (out_acc) begin
                r_out_valid <= 1'b0;
            end
            if (write_en) begin
                r_row_vld[r_set] <= 1'b1;
                r_out_valid      <= 1'b1;
                r_tot            <= sat_inc(r_tot, 1'b1);
                r_wt_hit_tot     <= sat_inc(r_wt_hit_tot, r_wt_hit);
                r_wt_mem_tot     <= sat_inc(r_wt_mem_tot, wt_mem);
                r_wb_hit_tot     <= sat_inc(r_wb_hit_tot, r_wb_hit);
                r_wb_mem_tot     <= sat_inc(r_wb_mem_tot, wb_mem);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_is_write <= i_req_type;
            r_tag      <= tag_in;
            r_set      <= set_in;
            r_way      <= '0;
            r_wt_hit   <= 1'b0;
            r_wb_hit   <= 1'b0;
            r_wt_inv   <= 1'b0;
            r_wb_inv   <= 1'b0;
        end
        if (scan_en) begin
            r_way <= scan_last ? r_way : r_way + AW'(1);
            if (!r_wt_hit && wt_vld && wt_tagr == r_tag) begin
                r_wt_hit  <= 1'b1;
                r_wt_hway <= r_way;
            end
            if (!r_wb_hit && wb_vld && wb_tagr == r_tag) begin
                r_wb_hit  <= 1'b1;
                r_wb_hway <= r_way;
            end
            if (!wt_vld) begin
                r_wt_inv  <= 1'b1;
                r_wt_iway <= r_way;
            end
            if (!wb_vld) begin
                r_wb_inv  <= 1'b1;
                r_wb_iway <= r_way;
            end
            if (r_way == '0 || wt_age > r_wt_bage) begin
                r_wt_bage <= wt_age;
                r_wt_bway <= r_way;
            end
            if (r_way == '0 || wb_age > r_wb_bage) begin
                r_wb_bage <= wb_age;
                r_wb_bway <= r_way;
            end
        end
        if (write_en) begin
            r_o_wt_hit   <= r_wt_hit;
            r_o_wt_mem   <= wt_mem;
            r_o_wb_hit   <= r_wb_hit;
            r_o_wb_mem   <= wb_mem;
            r_o_wb_evict <= wb_evict;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_wt_hit         = r_o_wt_hit;
    assign o_wt_mem_access  = r_o_wt_mem;
    assign o_wb_hit         = r_o_wb_hit;
    assign o_wb_mem_access  = r_o_wb_mem;
    assign o_wb_dirty_evict = r_o_wb_evict;
    assign o_total_refs     = r_tot;
    assign o_wt_hit_total   = r_wt_hit_tot;
    assign o_wt_mem_total   = r_wt_mem_tot;
    assign o_wb_hit_total   = r_wb_hit_tot;
    assign o_wb_mem_total   = r_wb_mem_tot;

    a_accept_reads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> r_state == dplc_pkg::S_READ)
        else $error("accepted item did not start a set read");

    a_scan_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == dplc_pkg::S_SCAN |-> WNW'(r_way) < ways_eff)
        else $error("scan way out of range");

    a_total_mono: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |-> r_tot >= $past(r_tot))
        else $error("access total decreased");

    a_hit_no_evict: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> !(r_o_wb_hit && r_o_wb_evict) && (r_o_wb_mem == !r_o_wb_hit))
        else $error("write-back flags inconsistent");

endmodule

@@ verif/dual_policy_lru_cache_model_tb.sv @@
// Dual-policy LRU cache testbench: directed and random accesses checked against a behavioral cache.
`timescale 1ns / 100ps

module dual_policy_lru_cache_model_tb;

    localparam int NSETS = dplc_pkg::MAX_SETS_DEF;
    localparam int NWAYS = dplc_pkg::MAX_WAYS_DEF;
    localparam int WATCHDOG_LIMIT = 20000;

    typedef struct packed {
        logic        req_type;
        logic [31:0] address;
    } t_access;

    typedef struct packed {
        logic        wt_hit;
        logic        wt_mem;
        logic        wb_hit;
        logic        wb_mem;
        logic        wb_evict;
        logic [31:0] refs;
        logic [31:0] wt_hits;
        logic [31:0] wt_mems;
        logic [31:0] wb_hits;
        logic [31:0] wb_mems;
    } t_outcome;

    logic                           i_clk = 1'b0;
    logic                           i_rst_n = 1'b0;
    logic                           i_cfg_we = 1'b0;
    logic [dplc_pkg::CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [dplc_pkg::CFG_W-1:0]     i_cfg_wdata = '0;
    logic                           i_in_valid = 1'b0;
    logic                           o_in_stall;
    logic                           i_req_type = 1'b0;
    logic [31:0]                    i_address = '0;
    logic                           o_out_valid;
    logic                           i_out_stall = 1'b0;
    logic                           o_wt_hit, o_wt_mem_access, o_wb_hit, o_wb_mem_access;
    logic                           o_wb_dirty_evict;
    logic [dplc_pkg::CNT_W-1:0]     o_total_refs, o_wt_hit_total, o_wt_mem_total;
    logic [dplc_pkg::CNT_W-1:0]     o_wb_hit_total, o_wb_mem_total;

    dual_policy_lru_cache_model DUT (.*);

    always #5 i_clk = ~i_clk;

    // behavioral cache state
    bit          wt_vld [NSETS][NWAYS];
    bit   [31:0] wt_tg  [NSETS][NWAYS];
    bit   [2:0]  wt_rank[NSETS][NWAYS];
    bit          wb_vld [NSETS][NWAYS];
    bit   [31:0] wb_tg  [NSETS][NWAYS];
    bit          wb_drt [NSETS][NWAYS];
    bit   [2:0]  wb_rank[NSETS][NWAYS];
    bit   [31:0] totals [5];
    int          cur_off = 4, cur_idx = 6, cur_ways = 4;

    t_access  pending_q[$];
    t_outcome expected_q[$];
    int       errors = 0, sent = 0, received = 0, idle_cycles = 0;

    function automatic void sat_bump(int k);
        if (totals[k] != 32'hFFFF_FFFF) totals[k]++;
    endfunction

    function automatic int pick_ways();
        if (cur_ways == 0) return 1;
        if (cur_ways > NWAYS) return NWAYS;
        return cur_ways;
    endfunction

    function automatic void touch_wt(int s, int nw, int w);
        bit [2:0] old;
        old = wt_rank[s][w];
        for (int k = 0; k < nw; k++)
            if (k != w && wt_rank[s][k] < old) wt_rank[s][k]++;
        wt_rank[s][w] = 0;
    endfunction

    function automatic void touch_wb(int s, int nw, int w);
        bit [2:0] old;
        old = wb_rank[s][w];
        for (int k = 0; k < nw; k++)
            if (k != w && wb_rank[s][k] < old) wb_rank[s][k]++;
        wb_rank[s][w] = 0;
    endfunction

    function automatic t_outcome predict_access(t_access a);
        t_outcome r;
        bit   [63:0] blk, tg64;
        bit   [31:0] tg;
        int          s, nw, sh, wtw, wbw, v;
        r = '0;
        blk = 64'(a.address) >> cur_off;
        sh = cur_off + cur_idx;
        tg64 = 64'(a.address) >> sh;
        tg = tg64[31:0];
        s = int'(blk & ((64'd1 << cur_idx) - 1)) % NSETS;
        nw = pick_ways();
        wtw = -1;
        wbw = -1;
        for (int w = nw - 1; w >= 0; w--) begin
            if (wt_vld[s][w] && wt_tg[s][w] == tg) wtw = w;
            if (wb_vld[s][w] && wb_tg[s][w] == tg) wbw = w;
        end
        r.wt_hit = wtw >= 0;
        r.wb_hit = wbw >= 0;
        r.wt_mem = a.req_type == dplc_pkg::REQ_WRITE || !r.wt_hit;
        r.wb_mem = !r.wb_hit;
        if (r.wt_hit) begin
            touch_wt(s, nw, wtw);
        end else if (a.req_type == dplc_pkg::REQ_READ) begin
            v = -1;
            for (int w = 0; w < nw; w++) if (!wt_vld[s][w]) v = w;
            if (v < 0) begin
                v = 0;
                for (int w = 1; w < nw; w++) if (wt_rank[s][w] > wt_rank[s][v]) v = w;
            end
            wt_vld[s][v] = 1;
            wt_tg[s][v] = tg;
            touch_wt(s, nw, v);
        end
        if (r.wb_hit) begin
            touch_wb(s, nw, wbw);
            if (a.req_type == dplc_pkg::REQ_WRITE) wb_drt[s][wbw] = 1;
        end else begin
            v = -1;
            for (int w = 0; w < nw; w++) if (!wb_vld[s][w]) v = w;
            if (v < 0) begin
                v = 0;
                for (int w = 1; w < nw; w++) if (wb_rank[s][w] > wb_rank[s][v]) v = w;
            end
            r.wb_evict = wb_vld[s][v] && wb_drt[s][v];
            wb_vld[s][v] = 1;
            wb_tg[s][v] = tg;
            wb_drt[s][v] = a.req_type == dplc_pkg::REQ_WRITE;
            touch_wb(s, nw, v);
        end
        sat_bump(0);
        if (r.wt_hit) sat_bump(1);
        if (r.wt_mem) sat_bump(2);
        if (r.wb_hit) sat_bump(3);
        if (r.wb_mem) sat_bump(4);
        r.refs = totals[0];
        r.wt_hits = totals[1];
        r.wt_mems = totals[2];
        r.wb_hits = totals[3];
        r.wb_mems = totals[4];
        return r;
    endfunction

    // driver: bursts with random gaps
    int burst_left = 0, gap_left = 0;
    always @(posedge i_clk) begin
        if (i_in_valid && !o_in_stall) begin
            expected_q.push_back(predict_access({i_req_type, i_address}));
            sent++;
        end
        if (!i_in_valid || !o_in_stall) begin
            if (gap_left > 0) begin
                gap_left--;
                i_in_valid <= 1'b0;
            end else if (pending_q.size() > 0) begin
                t_access a;
                a = pending_q.pop_front();
                i_in_valid <= 1'b1;
                i_req_type <= a.req_type;
                i_address <= a.address;
                if (burst_left > 0) begin
                    burst_left--;
                end else begin
                    burst_left = $urandom_range(0, 20);
                    gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 8);
                end
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // receiver stall pattern
    int stall_phase = 0;
    always @(posedge i_clk) begin
        stall_phase <= (stall_phase + 1) % 400;
        if (stall_phase < 100) i_out_stall <= 1'b0;
        else if (stall_phase < 250) i_out_stall <= ($urandom_range(0, 3) == 0);
        else i_out_stall <= ($urandom_range(0, 1) == 0);
    end

    // monitor
    always @(posedge i_clk) begin
        if (i_rst_n && ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            received++;
            if (expected_q.size() == 0) begin
                $error("result with no access pending");
                errors++;
            end else begin
                t_outcome e;
                e = expected_q.pop_front();
                if (o_wt_hit !== e.wt_hit) begin
                    $error("wt_hit exp %0d got %0d", e.wt_hit, o_wt_hit); errors++;
                end
                if (o_wt_mem_access !== e.wt_mem) begin
                    $error("wt_mem_access exp %0d got %0d", e.wt_mem, o_wt_mem_access);
                    errors++;
                end
                if (o_wb_hit !== e.wb_hit) begin
                    $error("wb_hit exp %0d got %0d", e.wb_hit, o_wb_hit); errors++;
                end
                if (o_wb_mem_access !== e.wb_mem) begin
                    $error("wb_mem_access exp %0d got %0d", e.wb_mem, o_wb_mem_access);
                    errors++;
                end
                if (o_wb_dirty_evict !== e.wb_evict) begin
                    $error("wb_dirty_evict exp %0d got %0d", e.wb_evict, o_wb_dirty_evict);
                    errors++;
                end
                if (o_total_refs !== e.refs) begin
                    $error("total_refs exp %0d got %0d", e.refs, o_total_refs); errors++;
                end
                if (o_wt_hit_total !== e.wt_hits) begin
                    $error("wt_hit_total exp %0d got %0d", e.wt_hits, o_wt_hit_total);
                    errors++;
                end
                if (o_wt_mem_total !== e.wt_mems) begin
                    $error("wt_mem_total exp %0d got %0d", e.wt_mems, o_wt_mem_total);
                    errors++;
                end
                if (o_wb_hit_total !== e.wb_hits) begin
                    $error("wb_hit_total exp %0d got %0d", e.wb_hits, o_wb_hit_total);
                    errors++;
                end
                if (o_wb_mem_total !== e.wb_mems) begin
                    $error("wb_mem_total exp %0d got %0d", e.wb_mems, o_wb_mem_total);
                    errors++;
                end
            end
        end
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog expired: sent %0d received %0d", sent, received);
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    task automatic add_access(bit kind, bit [31:0] addr);
        t_access a;
        a.req_type = kind;
        a.address = addr;
        pending_q.push_back(a);
    endtask

    task automatic drain_all();
        while (pending_q.size() > 0 || i_in_valid || expected_q.size() > 0)
            @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [dplc_pkg::CFG_IDX_W-1:0] idx, int val);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_wdata <= dplc_pkg::CFG_W'(val);
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            dplc_pkg::CFG_OFFSET_BITS: cur_off = val & 5'h1F;
            dplc_pkg::CFG_INDEX_BITS:  cur_idx = val & 4'hF;
            default:                   cur_ways = val & 4'hF;
        endcase
    endtask

    task automatic set_geometry(int off, int idx, int ways);
        write_reg(dplc_pkg::CFG_OFFSET_BITS, off);
        write_reg(dplc_pkg::CFG_INDEX_BITS, idx);
        write_reg(dplc_pkg::CFG_WAYS_IN_USE, ways);
    endtask

    // mostly reuse a small pool of blocks so sets fill, hit and evict
    task automatic random_phase(int n, int off, int idx);
        bit [31:0] pool[16];
        bit [31:0] a;
        int        sh;
        sh = off + idx;
        for (int k = 0; k < 16; k++) pool[k] = $urandom();
        for (int k = 0; k < n; k++) begin
            if ($urandom_range(0, 9) < 8) begin
                a = pool[$urandom_range(0, 15)];
                if (sh < 32)
                    a = (a & ((32'd1 << sh) - 32'd1)) | (((a >> sh) & 32'h7) << sh);
                a = a ^ ($urandom() & ((32'd1 << off) - 32'd1));
            end else begin
                a = $urandom();
            end
            add_access($urandom_range(0, 1), a);
        end
    endtask

    int geo[8][3] = '{'{4, 6, 4}, '{0, 0, 1}, '{16, 8, 8}, '{2, 2, 2},
                      '{5, 3, 0}, '{1, 1, 15}, '{3, 4, 3}, '{0, 8, 8}};

    initial begin
        for (int s = 0; s < NSETS; s++) begin
            for (int w = 0; w < NWAYS; w++) begin
                wt_rank[s][w] = 3'(w);
                wb_rank[s][w] = 3'(w);
            end
        end
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        add_access(dplc_pkg::REQ_READ, 32'h0000_0000);
        add_access(dplc_pkg::REQ_READ, 32'h0000_0000);
        add_access(dplc_pkg::REQ_WRITE, 32'h0000_0000);
        add_access(dplc_pkg::REQ_WRITE, 32'hFFFF_FFFF);
        add_access(dplc_pkg::REQ_READ, 32'hFFFF_FFFF);
        add_access(dplc_pkg::REQ_WRITE, 32'hFFFF_FFFF);
        for (int k = 0; k < 6; k++) add_access(dplc_pkg::REQ_WRITE, 32'(k) << 10);
        for (int k = 0; k < 6; k++) add_access(dplc_pkg::REQ_READ, 32'(k) << 10);
        add_access(dplc_pkg::REQ_WRITE, 32'h8000_0000);
        add_access(dplc_pkg::REQ_READ, 32'hAAAA_5555);
        add_access(dplc_pkg::REQ_READ, 32'h5555_AAAA);
        drain_all();
        for (int p = 0; p < 8; p++) begin
            set_geometry(geo[p][0], geo[p][1], geo[p][2]);
            random_phase(150, geo[p][0], geo[p][1] > 8 ? 8 : geo[p][1]);
            drain_all();
        end
        $display("covered %0d accesses over 8 cache geometries incl. extremes", received);
        $display("write-back hits %0d, write-through hits %0d", totals[3], totals[1]);
        if (errors == 0) $display("SCOREBOARD CLEAN");
        else $display("SCOREBOARD MISMATCH");
        $finish;
    end
endmodule
